// ===== rtl/hcbd_pkg.sv =====
package hcbd_pkg;

  localparam int unsigned SIZE_BITS_DEFAULT = 24;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_FINAL   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_EMPTY    = 2'd1;
  localparam logic [1:0] ERR_NEGATIVE = 2'd2;
  localparam logic [1:0] ERR_TOO_BIG  = 2'd3;

  // framing phase
  localparam logic [1:0] PH_LINE = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;

  // number scan phase
  localparam logic [2:0] NP_BLANK  = 3'd0;
  localparam logic [2:0] NP_SIGN   = 3'd1;
  localparam logic [2:0] NP_ZERO   = 3'd2;
  localparam logic [2:0] NP_PREFIX = 3'd3;
  localparam logic [2:0] NP_DIGITS = 3'd4;
  localparam logic [2:0] NP_DONE   = 3'd5;

  // characters
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_VT    = 8'h0b;
  localparam logic [7:0] CHAR_FF    = 8'h0c;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;
  localparam logic [7:0] CHAR_UC_X  = 8'h58;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] CHAR_LC_X  = 8'h78;

  localparam logic [1:0] TAIL_BYTES = 2'd2;

  // size line scan state, all but the value itself
  typedef struct packed {
    logic [2:0] np;
    logic       neg;
    logic       over;
    logic       has_char;
    logic       pending_cr;
  } line_state_t;

endpackage

// ===== rtl/hcbd_if.sv =====
interface hcbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface hcbd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload;
  logic       chunk_last;
  logic [1:0] error_code;

  modport source (output valid, output kind, output payload, output chunk_last,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input payload, input chunk_last,
                  input error_code, output ready);
endinterface

interface hcbd_cfg_if;
  logic valid;
  logic ready;
  logic chunked_mode;

  modport source (output valid, output chunked_mode, input ready);
  modport sink   (input valid, input chunked_mode, output ready);
endinterface

// ===== rtl/hcbd_line_parser.sv =====
module hcbd_line_parser #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic [7:0]                  byte_i,
  input  hcbd_pkg::line_state_t       state_i,
  input  logic [SIZE_BITS-1:0]        size_i,
  output hcbd_pkg::line_state_t       state_o,
  output logic [SIZE_BITS-1:0]        size_o,
  output logic                        line_end_o
);
  import hcbd_pkg::*;

  logic       is_blank;
  logic       is_dec;
  logic       is_alpha;
  logic       is_hex;
  logic [3:0] hex_d;
  logic       start;
  logic       add;
  line_state_t st;
  logic [SIZE_BITS-1:0] sz;

  assign is_blank = (byte_i == CHAR_SPACE) || (byte_i == CHAR_TAB) || (byte_i == CHAR_LF) ||
                    (byte_i == CHAR_VT) || (byte_i == CHAR_FF) || (byte_i == CHAR_CR);
  assign is_dec   = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign is_alpha = ((byte_i >= CHAR_LC_A) && (byte_i <= CHAR_LC_F)) ||
                    ((byte_i >= CHAR_UC_A) && (byte_i <= CHAR_UC_F));
  assign is_hex   = is_dec || is_alpha;
  // letters a..f / A..F have low nibble 1..6
  assign hex_d    = is_dec ? byte_i[3:0] : 4'(byte_i[3:0] + 4'd9);

  assign line_end_o = state_i.pending_cr && (byte_i == CHAR_LF);

  always_comb begin
    st    = state_i;
    sz    = size_i;
    start = 1'b0;
    add   = 1'b0;

    // a held CR that is not part of CR LF acts as a blank or ends the number
    if (st.pending_cr && (st.np != NP_BLANK)) begin
      st.np = NP_DONE;
    end

    case (st.np)
      NP_BLANK: begin
        if (!is_blank) begin
          if ((byte_i == CHAR_PLUS) || (byte_i == CHAR_MINUS)) begin
            st.neg = (byte_i == CHAR_MINUS);
            st.np  = NP_SIGN;
          end else begin
            start = 1'b1;
          end
        end
      end
      NP_SIGN: start = 1'b1;
      NP_ZERO: begin
        if ((byte_i == CHAR_LC_X) || (byte_i == CHAR_UC_X)) st.np = NP_PREFIX;
        else if (is_hex) add = 1'b1;
        else st.np = NP_DONE;
      end
      NP_PREFIX, NP_DIGITS: begin
        if (is_hex) add = 1'b1;
        else st.np = NP_DONE;
      end
      default: ;
    endcase

    if (start) begin
      if (byte_i == CHAR_ZERO) st.np = NP_ZERO;
      else if (is_hex) add = 1'b1;
      else st.np = NP_DONE;
    end

    if (add) begin
      st.np = NP_DIGITS;
      if (!st.over) begin
        if (sz[SIZE_BITS-1 -: 4] != 4'd0) begin
          st.over = 1'b1;
          sz      = '1;
        end else begin
          sz = {sz[SIZE_BITS-5:0], hex_d};
        end
      end
    end

    st.has_char   = state_i.has_char | state_i.pending_cr | (byte_i != CHAR_CR);
    st.pending_cr = (byte_i == CHAR_CR);
  end

  assign state_o = st;
  assign size_o  = sz;

endmodule

// ===== rtl/http_chunked_body_decoder_unit.sv =====
// Channel  Dir  Handshake     Word
// in_i     in   valid/ready   in_byte: raw body byte
// out_o    out  valid/ready   kind, payload, chunk_last, error_code
// cfg_i    in   valid/ready   chunked_mode (ready always high)
//
// One byte per cycle sustained while no result is stalled; a byte waits in the input register
// and its result, if any, is written to the result register when the byte advances.
// The byte-to-byte state update is one pass through the size-line scanner.
// Reset sets chunked mode and an empty size line; the error latch holds until reset.
// A stalled result blocks only bytes that produce a result; others drain past it.
module http_chunked_body_decoder_unit #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hcbd_byte_if.sink         in_i,
  hcbd_result_if.source     out_o,
  hcbd_cfg_if.sink          cfg_i
);
  import hcbd_pkg::*;

  logic                 mode_q;
  logic                 in_vld_q;
  logic [7:0]           in_byte_q;

  logic [1:0]           phase_q, phase_d;
  line_state_t          line_q, line_d, line_scan;
  logic [SIZE_BITS-1:0] size_q, size_d, size_scan;
  logic [SIZE_BITS-1:0] bytes_left_q, bytes_left_d;
  logic [1:0]           tail_q, tail_d;
  logic                 err_q, err_d;
  logic                 line_end;

  logic                 res_vld;
  logic [1:0]           res_kind;
  logic [7:0]           res_payload;
  logic                 res_last;
  logic [1:0]           res_code;

  logic                 out_vld_q;
  logic [1:0]           kind_q;
  logic [7:0]           payload_q;
  logic                 last_q;
  logic [1:0]           code_q;

  logic                 adv;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.chunked_mode;
    end
  end

  hcbd_line_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_line_parser (
    .byte_i     (in_byte_q),
    .state_i    (line_q),
    .size_i     (size_q),
    .state_o    (line_scan),
    .size_o     (size_scan),
    .line_end_o (line_end)
  );

  always_comb begin
    phase_d      = phase_q;
    line_d       = line_q;
    size_d       = size_q;
    bytes_left_d = bytes_left_q;
    tail_d       = tail_q;
    err_d        = err_q;
    res_vld      = 1'b0;
    res_kind     = KIND_PAYLOAD;
    res_payload  = 8'd0;
    res_last     = 1'b0;
    res_code     = ERR_NONE;

    if (!mode_q) begin
      res_vld     = 1'b1;
      res_payload = in_byte_q;
    end else if (!err_q) begin
      case (phase_q)
        PH_BODY: begin
          res_vld     = 1'b1;
          res_payload = in_byte_q;
          if (bytes_left_q != '0) bytes_left_d = bytes_left_q - SIZE_BITS'(1);
          if (bytes_left_q <= SIZE_BITS'(1)) begin
            res_last = 1'b1;
            phase_d  = PH_TAIL;
            tail_d   = TAIL_BYTES;
          end
        end
        PH_TAIL: begin
          if (tail_q != 2'd0) tail_d = tail_q - 2'd1;
          if (tail_q <= 2'd1) phase_d = PH_LINE;
        end
        default: begin
          if (line_end) begin
            line_d = '0;
            size_d = '0;
            if (!line_q.has_char) begin
              err_d    = 1'b1;
              res_vld  = 1'b1;
              res_kind = KIND_ERROR;
              res_code = ERR_EMPTY;
            end else if (line_q.neg && ((size_q != '0) || line_q.over)) begin
              err_d    = 1'b1;
              res_vld  = 1'b1;
              res_kind = KIND_ERROR;
              res_code = ERR_NEGATIVE;
            end else if (line_q.over) begin
              // saturated chunk still gets delivered
              bytes_left_d = '1;
              phase_d      = PH_BODY;
              res_vld      = 1'b1;
              res_kind     = KIND_ERROR;
              res_code     = ERR_TOO_BIG;
            end else if (size_q == '0) begin
              phase_d  = PH_TAIL;
              tail_d   = TAIL_BYTES;
              res_vld  = 1'b1;
              res_kind = KIND_FINAL;
            end else begin
              bytes_left_d = size_q;
              phase_d      = PH_BODY;
            end
          end else begin
            line_d = line_scan;
            size_d = size_scan;
          end
        end
      endcase
    end
  end

  assign adv        = in_vld_q && (!res_vld || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LINE;
      line_q       <= '0;
      size_q       <= '0;
      bytes_left_q <= '0;
      tail_q       <= 2'd0;
      err_q        <= 1'b0;
    end else if (adv) begin
      phase_q      <= phase_d;
      line_q       <= line_d;
      size_q       <= size_d;
      bytes_left_q <= bytes_left_d;
      tail_q       <= tail_d;
      err_q        <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      kind_q    <= res_kind;
      payload_q <= res_payload;
      last_q    <= res_last;
      code_q    <= res_code;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.kind       = kind_q;
  assign out_o.payload    = payload_q;
  assign out_o.chunk_last = last_q;
  assign out_o.error_code = code_q;

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("error latch cleared");

  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (bytes_left_q != '0))
    else $error("body phase with no bytes left");

  a_last_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && last_q) |-> (kind_q == KIND_PAYLOAD))
    else $error("chunk_last on a non-payload word");

  a_code_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (code_q != ERR_NONE)) |-> (kind_q == KIND_ERROR))
    else $error("error code on a non-error word");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> out_vld_q)
    else $error("stalled result lost");

endmodule

// ===== sim/http_chunked_body_decoder_unit_test.sv =====
`timescale 1ns / 1ps

module http_chunked_body_decoder_unit_test;
  import hcbd_pkg::*;

  localparam int SIZE_BITS = SIZE_BITS_DEFAULT;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_STALL = 240;
  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
    logic       chunk_last;
    logic [1:0] error_code;
  } result_t;

  // how the chunked stream is ended near the end of the run
  typedef enum int {
    END_EMPTY_LINE,
    END_NEGATIVE,
    END_OVERSIZE,
    END_FULL_SIZE
  } ending_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hcbd_byte_if   in_if ();
  hcbd_result_if out_if ();
  hcbd_cfg_if    cfg_if ();

  http_chunked_body_decoder_unit #(
    .SIZE_BITS(SIZE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  logic [7:0] pending_bytes[$];
  logic [7:0] framed_bytes[$];
  result_t    expected_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned rx_hold_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  // decoder model state
  logic                 pred_chunked;
  logic [1:0]           frame_phase;
  logic [2:0]           scan_phase;
  logic [SIZE_BITS-1:0] line_value;
  logic [SIZE_BITS-1:0] body_left;
  logic                 line_neg;
  logic                 line_over;
  logic                 line_has_char;
  logic                 line_cr;
  logic [1:0]           tail_left;
  logic                 err_latched;

  function automatic void frame_byte(input logic [7:0] b);
    framed_bytes.insert(framed_bytes.size(), b);
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
  endfunction

  function automatic logic [7:0] take_framed();
    logic [7:0] b;
    b = framed_bytes[0];
    framed_bytes.delete(0);
    return b;
  endfunction

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= CHAR_ZERO && b <= CHAR_NINE) return int'(b - CHAR_ZERO);
    if (b >= CHAR_LC_A && b <= CHAR_LC_F) return int'(b - CHAR_LC_A) + 10;
    if (b >= CHAR_UC_A && b <= CHAR_UC_F) return int'(b - CHAR_UC_A) + 10;
    return -1;
  endfunction

  function automatic bit is_space_char(input logic [7:0] b);
    return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF || b == CHAR_VT ||
           b == CHAR_FF || b == CHAR_CR;
  endfunction

  function automatic void clear_line();
    scan_phase    = NP_BLANK;
    line_value    = '0;
    line_neg      = 1'b0;
    line_over     = 1'b0;
    line_has_char = 1'b0;
    line_cr       = 1'b0;
  endfunction

  function automatic void clear_decoder();
    pred_chunked = 1'b1;
    frame_phase  = PH_LINE;
    body_left    = '0;
    tail_left    = '0;
    err_latched  = 1'b0;
    clear_line();
  endfunction

  function automatic void add_digit(input int d);
    logic [SIZE_BITS+3:0] v;
    if (line_over) return;
    v = {line_value, 4'b0000} + d[3:0];
    if (v > {4'b0000, SIZE_MAX}) begin
      line_over  = 1'b1;
      line_value = SIZE_MAX;
    end else begin
      line_value = v[SIZE_BITS-1:0];
    end
  endfunction

  function automatic void feed_number(input logic [7:0] b);
    int d;
    d = hex_digit(b);
    if (scan_phase == NP_BLANK) begin
      if (is_space_char(b)) return;
      if (b == CHAR_PLUS || b == CHAR_MINUS) begin
        line_neg   = (b == CHAR_MINUS);
        scan_phase = NP_SIGN;
        return;
      end
      scan_phase = NP_SIGN;
    end
    case (scan_phase)
      NP_SIGN: begin
        if (b == CHAR_ZERO) scan_phase = NP_ZERO;
        else if (d >= 0) begin
          add_digit(d);
          scan_phase = NP_DIGITS;
        end else scan_phase = NP_DONE;
      end
      NP_ZERO: begin
        if (b == CHAR_LC_X || b == CHAR_UC_X) scan_phase = NP_PREFIX;
        else if (d >= 0) begin
          add_digit(d);
          scan_phase = NP_DIGITS;
        end else scan_phase = NP_DONE;
      end
      NP_PREFIX, NP_DIGITS: begin
        if (d >= 0) begin
          add_digit(d);
          scan_phase = NP_DIGITS;
        end else scan_phase = NP_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic bit end_line(output result_t r);
    bit hit;
    hit = 1'b1;
    r   = '0;
    if (!line_has_char) begin
      err_latched  = 1'b1;
      r.kind       = KIND_ERROR;
      r.error_code = ERR_EMPTY;
    end else if (line_neg && (line_value != 0 || line_over)) begin
      err_latched  = 1'b1;
      r.kind       = KIND_ERROR;
      r.error_code = ERR_NEGATIVE;
    end else if (line_over) begin
      body_left    = SIZE_MAX;
      frame_phase  = PH_BODY;
      r.kind       = KIND_ERROR;
      r.error_code = ERR_TOO_BIG;
    end else if (line_value == 0) begin
      frame_phase = PH_TAIL;
      tail_left   = TAIL_BYTES;
      r.kind      = KIND_FINAL;
    end else begin
      body_left   = line_value;
      frame_phase = PH_BODY;
      hit         = 1'b0;
    end
    clear_line();
    return hit;
  endfunction

  // advance the model by one body byte; returns 1 when the byte yields a word
  function automatic bit decode_byte(input logic [7:0] b, output result_t r);
    r = '0;
    if (!pred_chunked) begin
      r.kind    = KIND_PAYLOAD;
      r.payload = b;
      return 1'b1;
    end
    if (err_latched) return 1'b0;
    if (frame_phase == PH_BODY) begin
      if (body_left != 0) body_left = body_left - SIZE_BITS'(1);
      r.kind    = KIND_PAYLOAD;
      r.payload = b;
      if (body_left == 0) begin
        frame_phase  = PH_TAIL;
        tail_left    = TAIL_BYTES;
        r.chunk_last = 1'b1;
      end
      return 1'b1;
    end
    if (frame_phase == PH_TAIL) begin
      if (tail_left != 0) tail_left = tail_left - 2'd1;
      if (tail_left == 0) frame_phase = PH_LINE;
      return 1'b0;
    end
    if (line_cr) begin
      if (b == CHAR_LF) return end_line(r);
      // CR without LF is an ordinary line character
      line_cr       = 1'b0;
      line_has_char = 1'b1;
      feed_number(CHAR_CR);
    end
    if (b == CHAR_CR) begin
      line_cr = 1'b1;
    end else begin
      line_has_char = 1'b1;
      if (b == 8'h00) scan_phase = NP_DONE;
      else feed_number(b);
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("mismatch at %0t ns: %s", $realtime, what);
  endtask

  // ---------------- stimulus generation ----------------

  function automatic logic [7:0] pick_blank(input bit no_lf);
    case ($urandom_range(no_lf ? 3 : 4))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      2: return CHAR_VT;
      3: return CHAR_FF;
      default: return CHAR_LF;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input int d);
    if (d < 10) return CHAR_ZERO + 8'(d);
    return ($urandom_range(1) ? CHAR_UC_A : CHAR_LC_A) + 8'(d - 10);
  endfunction

  // a byte that stops the size number without starting a 0x prefix
  function automatic logic [7:0] pick_terminator();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (hex_digit(b) >= 0 || b == CHAR_CR || b == CHAR_LC_X || b == CHAR_UC_X);
    return b;
  endfunction

  task automatic add_junk(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (b == CHAR_CR) begin
        frame_byte(CHAR_CR);
        do b = 8'($urandom_range(255)); while (b == CHAR_LF || b == CHAR_CR);
      end
      frame_byte(b);
    end
  endtask

  task automatic add_hex(input logic [31:0] v, input int zeros);
    int top;
    top = 7;
    while (top > 0 && v[top*4 +: 4] == 0) top--;
    repeat (zeros) frame_byte(CHAR_ZERO);
    for (int i = top; i >= 0; i--) frame_byte(hex_char(int'(v[i*4 +: 4])));
  endtask

  // one well-formed chunk: size line, payload, two trailing bytes
  task automatic build_chunk();
    int n;
    int sel;
    bit prefix;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 6) begin
      // line with no number in it reads as size zero
      do b = pick_terminator(); while (is_space_char(b) || b == CHAR_PLUS || b == CHAR_MINUS);
      frame_byte(b);
      add_junk($urandom_range(0, 4));
      n = 0;
    end else begin
      if (sel < 14) n = 0;
      else if (sel < 95) n = $urandom_range(1, 12);
      else n = $urandom_range(13, 300);
      repeat ($urandom_range(0, 2)) frame_byte(pick_blank(1'b0));
      if ($urandom_range(9) == 0) begin
        frame_byte(CHAR_CR);
        frame_byte(pick_blank(1'b1));
      end
      sel = $urandom_range(9);
      if (sel < 2) frame_byte(CHAR_PLUS);
      else if (sel == 2 && n == 0) frame_byte(CHAR_MINUS);
      prefix = ($urandom_range(9) < 3);
      if (prefix) begin
        frame_byte(CHAR_ZERO);
        frame_byte($urandom_range(1) ? CHAR_LC_X : CHAR_UC_X);
      end
      if (!prefix || n != 0 || $urandom_range(1)) add_hex(n, $urandom_range(0, 2));
      if ($urandom_range(9) < 4) begin
        frame_byte(pick_terminator());
        add_junk($urandom_range(0, 5));
      end
    end
    frame_byte(CHAR_CR);
    frame_byte(CHAR_LF);
    repeat (n) frame_byte(8'($urandom_range(255)));
    repeat (2) frame_byte(8'($urandom_range(255)));
  endtask

  task automatic build_sticky(input ending_t which);
    case (which)
      END_EMPTY_LINE: ;
      END_NEGATIVE: begin
        frame_byte(CHAR_MINUS);
        frame_byte(hex_char($urandom_range(1, 15)));
        repeat ($urandom_range(0, 8)) frame_byte(hex_char($urandom_range(15)));
      end
      END_OVERSIZE: begin
        if ($urandom_range(1)) frame_byte(CHAR_PLUS);
        frame_byte(hex_char($urandom_range(1, 15)));
        repeat ($urandom_range(6, 9)) frame_byte(hex_char($urandom_range(15)));
      end
      default: begin
        repeat ($urandom_range(0, 2)) frame_byte(CHAR_ZERO);
        repeat (SIZE_BITS / 4) frame_byte(hex_char(15));
      end
    endcase
    frame_byte(CHAR_CR);
    frame_byte(CHAR_LF);
  endtask

  // cuts the chunk stream anywhere; the rest carries into the next chunked phase
  task automatic queue_chunked(input int count);
    repeat (count) begin
      if (framed_bytes.size() == 0) build_chunk();
      queue_byte(take_framed());
    end
  endtask

  task automatic flush_framed();
    while (framed_bytes.size() != 0) queue_byte(take_framed());
  endtask

  task automatic queue_random(input int count);
    repeat (count) queue_byte(8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_if.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.chunked_mode <= m;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    pred_chunked <= m;
    @(negedge clk_i);
  endtask

  // ---------------- byte driver ----------------
  always @(posedge clk_i) begin
    result_t r;
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        if (decode_byte(in_if.in_byte, r)) begin
          expected_results.insert(expected_results.size(), r);
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid   <= 1'b1;
          in_if.in_byte <= pending_bytes[0];
          pending_bytes.delete(0);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- long receiver hold-off ----------------
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_requests != hold_served) begin
      rx_hold_left <= LONG_STALL;
      hold_served  <= hold_served + 1;
    end
  end

  // ---------------- result monitor ----------------
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected word: kind %0d payload %02h last %0d code %0d",
                                    out_if.kind, out_if.payload, out_if.chunk_last,
                                    out_if.error_code));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_if.kind !== want.kind || out_if.payload !== want.payload ||
              out_if.chunk_last !== want.chunk_last || out_if.error_code !== want.error_code)
            report_mismatch($sformatf(
              "kind %0d/%0d payload %02h/%02h last %0d/%0d code %0d/%0d (got/exp)",
              out_if.kind, want.kind, out_if.payload, want.payload,
              out_if.chunk_last, want.chunk_last, out_if.error_code, want.error_code));
        end
      end
      out_if.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    ending_t ending;
    rst_ni              = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.chunked_mode = 1'b0;
    send_idle_pct       = 38;
    recv_idle_pct       = 72;
    clear_decoder();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_mode(1'b1);
    // "-0" after blanks, then "+0X" with a lone CR and no digit, then a lone CR
    // before the number and a NUL cutting it short
    pending_bytes = '{CHAR_SPACE, CHAR_TAB, CHAR_MINUS, CHAR_ZERO, CHAR_CR, CHAR_LF,
                      8'hff, 8'h00,
                      CHAR_PLUS, CHAR_ZERO, CHAR_UC_X, CHAR_CR, 8'h7a, CHAR_CR, CHAR_LF,
                      CHAR_CR, CHAR_LF,
                      CHAR_CR, CHAR_ZERO + 8'd2, 8'h00, CHAR_ZERO + 8'd5, CHAR_CR, CHAR_LF,
                      8'h00, 8'hff, CHAR_CR, CHAR_LF};
    wait_drained();
    write_mode(1'b0);
    pending_bytes = '{8'h00, 8'hff, CHAR_CR, CHAR_LF};
    wait_drained();

    write_mode(1'b1);
    queue_chunked(60);
    wait_drained();
    write_mode(1'b0);
    queue_random(30);
    wait_drained();

    send_idle_pct = 72;
    recv_idle_pct = 38;
    write_mode(1'b1);
    queue_chunked(40);
    wait_drained();
    queue_chunked(40);
    wait_drained();
    write_mode(1'b0);
    queue_random(20);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_mode(1'b1);
    queue_chunked(100);
    hold_requests++;
    wait_drained();
    queue_chunked(40);
    flush_framed();
    wait_drained();

    // sticky endings: only one of them can be reached before reset
    ending = ending_t'($urandom_range(3));
    build_sticky(ending);
    flush_framed();
    queue_random(20);
    wait_drained();
    write_mode(1'b0);
    queue_random(10);
    wait_drained();
    write_mode(1'b1);
    queue_random(10);
    wait_drained();

    repeat (8) @(negedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_results.size()));
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
